[rtl/lli_pkg.sv]
// lli_pkg: widths, payload types and stage record for the line intersection block
// depends on nothing
`default_nettype none
package lli_pkg;
  localparam int CoordW = 16;
  localparam int DiffW  = 17;
  localparam int DetW   = 35;
  localparam int NumW   = 53;
  localparam int OutW   = 32;
  localparam int DivSteps = NumW;

  typedef struct packed {
    logic signed [CoordW-1:0] line_a_start_x;
    logic signed [CoordW-1:0] line_a_start_y;
    logic signed [CoordW-1:0] line_a_end_x;
    logic signed [CoordW-1:0] line_a_end_y;
    logic signed [CoordW-1:0] line_b_start_x;
    logic signed [CoordW-1:0] line_b_start_y;
    logic signed [CoordW-1:0] line_b_end_x;
    logic signed [CoordW-1:0] line_b_end_y;
  } lines_t;

  typedef struct packed {
    logic signed [OutW-1:0] cross_x;
    logic signed [OutW-1:0] cross_y;
    logic                   parallel;
    logic                   overflow;
  } point_t;

  // one restoring divide cell state: two quotients share one divisor
  typedef struct packed {
    logic              vld;
    logic [NumW-1:0]   den;
    logic [NumW-1:0]   rem_x;
    logic [NumW-1:0]   num_x;
    logic [NumW-1:0]   rem_y;
    logic [NumW-1:0]   num_y;
    logic              neg_x;
    logic              neg_y;
    logic              par;
  } div_t;
endpackage
`default_nettype wire

[rtl/lli_if.sv]
// lli_if: valid/ready channel carrying one payload item
// depends on lli_pkg
`default_nettype none
interface lli_in_if;
  logic            valid;
  logic            ready;
  lli_pkg::lines_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lli_out_if;
  logic            valid;
  logic            ready;
  lli_pkg::point_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/line_line_intersection.sv]
// line_line_intersection: top level, front products, divide cell chain, output stage
// depends on lli_pkg, lli_if, lli_front, lli_div_cell, lli_back
// pipeline: 3 product stages, 53 divide cells and 1 output register
// throughput: one item per cycle when not stalled; the whole chain advances together
// the chain stalls only when the output register is full and not taken
// reset clears all valid flags; payload registers are not reset
`default_nettype none
module line_line_intersection (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lli_in_if.sink    in_i,
  lli_out_if.source out_o
);
  localparam int Steps = lli_pkg::DivSteps;

  // global advance: move when the output slot is empty or being taken
  logic            adv;
  logic            out_vld_q;
  lli_pkg::point_t out_q, pt;
  lli_pkg::div_t   chain [Steps+1];

  assign adv         = !out_vld_q || out_o.ready;
  assign in_i.ready  = adv;

  // products, determinant, numerators and operand magnitudes
  lli_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .vld_i   (in_i.valid),
    .lines_i (in_i.data),
    .cell_o  (chain[0])
  );

  // one quotient bit per cell, most significant first
  for (genvar g = 0; g < Steps; g++) begin : g_cell
    lli_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  lli_back u_back (
    .cell_i  (chain[Steps]),
    .point_o (pt)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= chain[Steps].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= pt;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;
endmodule
`default_nettype wire

[rtl/lli_front.sv]
// lli_front: differences, determinant and numerators over three registered stages
// depends on lli_pkg
`default_nettype none
module lli_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            vld_i,
  input  wire lli_pkg::lines_t lines_i,
  output lli_pkg::div_t        cell_o
);
  localparam int DiffW = lli_pkg::DiffW;
  localparam int DetW  = lli_pkg::DetW;
  localparam int NumW  = lli_pkg::NumW;

  logic                              v1_q, v2_q, v3_q;
  logic signed [lli_pkg::DiffW-1:0]  adx_q, ady_q, bdx_q, bdy_q;
  logic signed [lli_pkg::DetW-1:0]   ca_q, cb_q;
  logic signed [lli_pkg::DiffW-1:0]  adx2_q, ady2_q, bdx2_q, bdy2_q;
  logic signed [lli_pkg::DetW-1:0]   d_q, ca2_q, cb2_q;
  logic signed [lli_pkg::NumW-1:0]   nx_q, ny_q, nxa, nya;
  logic signed [lli_pkg::DetW-1:0]   d3_q;
  logic signed [lli_pkg::NumW-1:0]   d_ext;
  logic                              nxn, nyn, dn;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      adx_q <= DiffW'(lines_i.line_a_start_x) - DiffW'(lines_i.line_a_end_x);
      ady_q <= DiffW'(lines_i.line_a_start_y) - DiffW'(lines_i.line_a_end_y);
      bdx_q <= DiffW'(lines_i.line_b_start_x) - DiffW'(lines_i.line_b_end_x);
      bdy_q <= DiffW'(lines_i.line_b_start_y) - DiffW'(lines_i.line_b_end_y);
      ca_q  <= DetW'(lines_i.line_a_start_x * lines_i.line_a_end_y)
             - DetW'(lines_i.line_a_start_y * lines_i.line_a_end_x);
      cb_q  <= DetW'(lines_i.line_b_start_x * lines_i.line_b_end_y)
             - DetW'(lines_i.line_b_start_y * lines_i.line_b_end_x);
      // stage 2: determinant
      d_q    <= DetW'(adx_q * bdy_q) - DetW'(ady_q * bdx_q);
      ca2_q  <= ca_q;
      cb2_q  <= cb_q;
      adx2_q <= adx_q;
      ady2_q <= ady_q;
      bdx2_q <= bdx_q;
      bdy2_q <= bdy_q;
      // stage 3: numerators
      nx_q   <= NumW'(ca2_q * bdx2_q) - NumW'(cb2_q * adx2_q);
      ny_q   <= NumW'(ca2_q * bdy2_q) - NumW'(cb2_q * ady2_q);
      d3_q   <= d_q;
    end
  end

  always_comb begin
    d_ext = NumW'(d3_q);
    dn    = d_ext[NumW-1];
    nxn   = nx_q[NumW-1];
    nyn   = ny_q[NumW-1];
    nxa   = nxn ? -nx_q : nx_q;
    nya   = nyn ? -ny_q : ny_q;
    cell_o.vld   = v3_q;
    cell_o.den   = dn ? NumW'(-d_ext) : NumW'(d_ext);
    cell_o.rem_x = '0;
    cell_o.num_x = nxa;
    cell_o.rem_y = '0;
    cell_o.num_y = nya;
    cell_o.neg_x = nxn ^ dn;
    cell_o.neg_y = nyn ^ dn;
    cell_o.par   = (d3_q == '0);
  end
endmodule
`default_nettype wire

[rtl/lli_div_cell.sv]
// lli_div_cell: one restoring divide step for both quotients, registered
// depends on lli_pkg
`default_nettype none
module lli_div_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire lli_pkg::div_t cell_i,
  output lli_pkg::div_t      cell_o
);
  localparam int NumW = lli_pkg::NumW;
  lli_pkg::div_t   c_d, c_q;
  logic            vld_q;
  logic [NumW:0]   tx, ty;

  always_comb begin
    c_d   = cell_i;
    tx    = {cell_i.rem_x, cell_i.num_x[NumW-1]};
    ty    = {cell_i.rem_y, cell_i.num_y[NumW-1]};
    if (tx >= {1'b0, cell_i.den}) begin
      tx = tx - {1'b0, cell_i.den};
      c_d.num_x = {cell_i.num_x[NumW-2:0], 1'b1};
    end else begin
      c_d.num_x = {cell_i.num_x[NumW-2:0], 1'b0};
    end
    if (ty >= {1'b0, cell_i.den}) begin
      ty = ty - {1'b0, cell_i.den};
      c_d.num_y = {cell_i.num_y[NumW-2:0], 1'b1};
    end else begin
      c_d.num_y = {cell_i.num_y[NumW-2:0], 1'b0};
    end
    c_d.rem_x = tx[NumW-1:0];
    c_d.rem_y = ty[NumW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= c_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end

  always_comb begin
    cell_o     = c_q;
    cell_o.vld = vld_q;
  end
endmodule
`default_nettype wire

[rtl/lli_back.sv]
// lli_back: sign fix, saturation and parallel handling of the final quotients
// depends on lli_pkg
`default_nettype none
module lli_back (
  input  wire lli_pkg::div_t cell_i,
  output lli_pkg::point_t    point_o
);
  localparam int NumW = lli_pkg::NumW;
  localparam int OutW = lli_pkg::OutW;
  logic signed [NumW:0] qx, qy;
  logic                 ox, oy;
  logic [OutW-1:0]      sx, sy;

  function automatic logic [OutW:0] sat(input logic signed [NumW:0] q);
    logic [OutW:0] r;
    if (q > (NumW+1)'(signed'(33'sh0_7FFF_FFFF))) begin
      r = {1'b1, 1'b0, {(OutW-1){1'b1}}};
    end else if (q < -(NumW+1)'(signed'(33'sh0_8000_0000))) begin
      r = {1'b1, 1'b1, {(OutW-1){1'b0}}};
    end else begin
      r = {1'b0, q[OutW-1:0]};
    end
    return r;
  endfunction

  always_comb begin
    qx = cell_i.neg_x ? -$signed({1'b0, cell_i.num_x}) : $signed({1'b0, cell_i.num_x});
    qy = cell_i.neg_y ? -$signed({1'b0, cell_i.num_y}) : $signed({1'b0, cell_i.num_y});
    {ox, sx} = sat(qx);
    {oy, sy} = sat(qy);
    if (cell_i.par) begin
      point_o.cross_x  = '0;
      point_o.cross_y  = '0;
      point_o.parallel = 1'b1;
      point_o.overflow = 1'b0;
    end else begin
      point_o.cross_x  = sx;
      point_o.cross_y  = sy;
      point_o.parallel = 1'b0;
      point_o.overflow = ox | oy;
    end
  end
endmodule
`default_nettype wire

[rtl/lli_checker.sv]
// lli_checker: port-level checks of the line intersection block
// depends on lli_pkg, lli_if, line_line_intersection
`default_nettype none
module lli_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_ready_i,
  input wire logic            out_valid_i,
  input wire logic            out_ready_i,
  input wire lli_pkg::point_t out_data_i
);
  // a parallel result carries zero coordinates
  a_par_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.parallel |-> out_data_i.cross_x == '0
      && out_data_i.cross_y == '0 && !out_data_i.overflow)
    else $error("parallel result not zero");
  // the input side stalls exactly when a result waits untaken
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i)) else $error("ready mismatch");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result dropped");
endmodule

bind line_line_intersection lli_checker u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
`default_nettype wire

[test/tb_line_line_intersection.sv]
// tb_line_line_intersection: stimulus, intersection predictor and result checking
// depends on lli_pkg, lli_if and the line_line_intersection top level
`timescale 1ns / 1ps
module tb_line_line_intersection;

  // queue of predicted intersection results, checked in order of arrival
  class point_board;
    lli_pkg::point_t pending[$];
    int              errors;

    function new();
      errors = 0;
    endfunction

    function logic [31:0] clip(longint q, inout logic ovf);
      if (q > 64'sd2147483647) begin
        ovf = 1'b1;
        return 32'h7fffffff;
      end
      if (q < -64'sd2147483648) begin
        ovf = 1'b1;
        return 32'h80000000;
      end
      return q[31:0];
    endfunction

    // works out the intersection of the two lines of one accepted item
    function void note_lines(lli_pkg::lines_t l);
      longint ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
      longint adx, ady, bdx, bdy, det, ca, cb, qx, qy;
      lli_pkg::point_t p;
      ax1 = l.line_a_start_x; ay1 = l.line_a_start_y;
      ax2 = l.line_a_end_x;   ay2 = l.line_a_end_y;
      bx1 = l.line_b_start_x; by1 = l.line_b_start_y;
      bx2 = l.line_b_end_x;   by2 = l.line_b_end_y;
      adx = ax1 - ax2; ady = ay1 - ay2;
      bdx = bx1 - bx2; bdy = by1 - by2;
      det = adx * bdy - ady * bdx;
      ca = ax1 * ay2 - ay1 * ax2;
      cb = bx1 * by2 - by1 * bx2;
      p = '0;
      if (det == 0) begin
        p.parallel = 1'b1;
      end else begin
        // signed division in SystemVerilog truncates toward zero
        qx = (ca * bdx - cb * adx) / det;
        qy = (ca * bdy - cb * ady) / det;
        p.cross_x = clip(qx, p.overflow);
        p.cross_y = clip(qy, p.overflow);
      end
      pending.push_back(p);
    endfunction

    function void check_point(lli_pkg::point_t got);
      lli_pkg::point_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.cross_x !== want.cross_x) begin
        $display("%0t: cross_x expected %h actual %h", $time, want.cross_x, got.cross_x);
        errors++;
      end
      if (got.cross_y !== want.cross_y) begin
        $display("%0t: cross_y expected %h actual %h", $time, want.cross_y, got.cross_y);
        errors++;
      end
      if (got.parallel !== want.parallel) begin
        $display("%0t: parallel expected %b actual %b", $time, want.parallel, got.parallel);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $display("%0t: overflow expected %b actual %b", $time, want.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   calm;   // no idling in the closing stretch

  lli_in_if  lines_ch ();
  lli_out_if point_ch ();

  line_line_intersection u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (lines_ch.sink),
    .out_o  (point_ch.source)
  );

  point_board board = new();

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // sink side: ready drops in random bursts
  int stall_left;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_left <= 0;
      point_ch.ready <= 1'b0;
    end else begin
      if (point_ch.valid && point_ch.ready) begin
        board.check_point(point_ch.data);
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        point_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 3);
        point_ch.ready <= 1'b0;
      end else begin
        point_ch.ready <= 1'b1;
      end
    end
  end

  // hands one item to the block and waits for it to be taken
  task automatic send_lines(lli_pkg::lines_t l);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      lines_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    lines_ch.valid <= 1'b1;
    lines_ch.data  <= l;
    do @(posedge clk_i); while (!lines_ch.ready);
    board.note_lines(l);
  endtask

  function automatic logic [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 2047)) - 1024);
      2: return ($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(0, 63)) - 32);
    endcase
  endfunction

  function automatic lli_pkg::lines_t rand_lines();
    lli_pkg::lines_t l;
    int mode;
    mode = $urandom_range(0, 3);
    l = {rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
         rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode)};
    case ($urandom_range(0, 7))
      0: begin
        // line B parallel to line A, shifted
        l.line_b_end_x = l.line_b_start_x + l.line_a_end_x - l.line_a_start_x;
        l.line_b_end_y = l.line_b_start_y + l.line_a_end_y - l.line_a_start_y;
      end
      1: begin
        // degenerate line A: both points equal
        l.line_a_end_x = l.line_a_start_x;
        l.line_a_end_y = l.line_a_start_y;
      end
      2: begin
        // nearly parallel, far away intersection, tends to saturate
        l.line_b_end_x = l.line_b_start_x + l.line_a_end_x - l.line_a_start_x + 1;
        l.line_b_end_y = l.line_b_start_y + l.line_a_end_y - l.line_a_start_y;
      end
      default: ;
    endcase
    return l;
  endfunction

  initial begin
    lines_ch.valid = 1'b0;
    lines_ch.data  = '0;
    calm   = 1'b0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: axis crossing, extremes, parallel, degenerate, saturation
    send_lines({16'sd0, 16'sd0, 16'sd256, 16'sd256, 16'sd0, 16'sd256, 16'sd256, 16'sd0});
    send_lines({16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd256});
    send_lines({16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000});
    send_lines({16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff});
    send_lines({16'sd0, 16'sd0, 16'sd256, 16'sd256, 16'sd0, 16'sd10, 16'sd256, 16'sd266});
    send_lines({16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd0, 16'sd0, 16'sd9, 16'sd3});
    send_lines('0);
    send_lines({8{16'hffff}});
    send_lines({16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7ffe});
    send_lines({16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8001, 16'h8000, 16'h7fff});
    send_lines({16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd3, 16'sd0, 16'sd0, 16'sd3});
    send_lines({16'sd0, 16'sd0, 16'sd3, 16'sd1, 16'sd0, 16'sd1, 16'sd3, 16'sd0});

    for (int i = 0; i < 540; i++) begin
      if (i == 440) calm = 1'b1;
      send_lines(rand_lines());
    end
    lines_ch.valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end
endmodule

[files.f]
rtl/lli_pkg.sv
rtl/lli_if.sv
rtl/lli_front.sv
rtl/lli_div_cell.sv
rtl/lli_back.sv
rtl/line_line_intersection.sv
rtl/lli_checker.sv
test/tb_line_line_intersection.sv
